>>> rtl/frl_pkg.sv
// shared types, constants and codes of the flood rate limiter
package frl_pkg;

	localparam int UID_W    = 8;
	localparam int TIME_W   = 32;
	localparam int LEVEL_W  = 32;
	localparam int AMOUNT_W = 16;
	localparam int OFF_W    = 4;
	localparam int MSGS_W   = 10;
	localparam int FTIME_W  = 16;
	localparam int CODE_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int FRL_USERS       = 256;
	localparam int FRL_LEVEL_SCALE = 10;
	localparam int FRL_LIM_W       = MSGS_W + $clog2(FRL_LEVEL_SCALE + 1);

	localparam logic [TIME_W-1:0] IGNORE_SECONDS    = TIME_W'(30);
	localparam logic [OFF_W-1:0]  OFF_BASE          = OFF_W'(10);
	localparam logic [OFF_W-1:0]  OFF_FIRST_IGNORE  = OFF_W'(11);
	localparam logic [OFF_W-1:0]  OFF_LAST_IGNORE   = OFF_W'(12);
	localparam logic [OFF_W-1:0]  OFF_CLEAN         = OFF_W'(0);
	localparam logic [OFF_W-1:0]  OFF_ONCE          = OFF_W'(1);
	localparam logic [OFF_W-1:0]  OFF_TWICE         = OFF_W'(2);
	localparam logic [LEVEL_W-1:0] LEVEL_MAX        = '1;

	typedef enum logic {
		ACT_CHECK = 1'b0,
		ACT_ADD   = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MSG_QUOTA = 1'b0,
		CFG_WINDOW    = 1'b1
	} cfg_idx_t;

	typedef enum logic [CODE_W-1:0] {
		NOTICE_NONE   = 3'd0,
		NOTICE_IGNORE = 3'd1,
		NOTICE_FIRST  = 3'd2,
		NOTICE_LAST   = 3'd3,
		NOTICE_BAN    = 3'd4
	} notice_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DIV,
		ST_MUL,
		ST_SUB,
		ST_ADD,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]  last_seen;
		logic [OFF_W-1:0]   offense;
	} entry_t;

	typedef struct packed {
		action_t             action;
		logic [TIME_W-1:0]   now;
		logic [AMOUNT_W-1:0] amount;
		logic                ignored;
		logic                admin;
		logic                may_flood;
		logic                foreign;
	} item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

>>> rtl/frl_if.sv
// channel interfaces: message items, results and register writes
interface frl_msg_if;
	import frl_pkg::*;
	logic                valid;
	logic                ready;
	logic                action;
	logic [UID_W-1:0]    user_id;
	logic [TIME_W-1:0]   current_time;
	logic [AMOUNT_W-1:0] amount;
	logic                on_ignore_list;
	logic                is_admin;
	logic                may_flood;
	logic                target_foreign;
	modport source (output valid, action, user_id, current_time, amount, on_ignore_list,
		is_admin, may_flood, target_foreign, input ready);
	modport sink (input valid, action, user_id, current_time, amount, on_ignore_list,
		is_admin, may_flood, target_foreign, output ready);
endinterface

interface frl_res_if;
	import frl_pkg::*;
	logic              valid;
	logic              ready;
	logic              drop;
	logic [CODE_W-1:0] notice_code;
	modport source (output valid, drop, notice_code, input ready);
	modport sink (input valid, drop, notice_code, output ready);
endinterface

interface frl_cfg_if;
	import frl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/frl_div.sv
// bit-serial restoring divider for the per-second drain rate
module frl_div #(
	parameter int DW = frl_pkg::FRL_LIM_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DW-1:0]               dividend,
	input  logic [frl_pkg::FTIME_W-1:0] divisor,
	output logic [DW-1:0]               quotient,
	output frl_pkg::div_sts_t           sts
);
	import frl_pkg::*;

	localparam int CNT_W = $clog2(DW + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [FTIME_W-1:0]  rem_q;
	logic [FTIME_W-1:0]  dvs_q;
	logic [DW-1:0]       quo_q;
	logic [FTIME_W:0]    shifted;
	logic [FTIME_W:0]    diff;
	logic                ge;
	logic                last;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign last    = cnt_q == CNT_W'(DW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FTIME_W-1:0] : shifted[FTIME_W-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

>>> rtl/flood_rate_limiter_unit.sv
// top level: per-user leaky-bucket message policer with sequencer and user table
// One item at a time. After reset the user table is cleared one entry per cycle, all
// USERS entries, before the first item is taken. A check that reaches the limit compare
// passes from transfer to result through table read, decision, level add, limit compare
// and write back when no drain applies; adds, foreign targets, ignore-listed users,
// disabled policing, a running ignore period and an out-of-range user are settled at the
// decision and go on to write back. A check that drains an earlier level also passes the
// LIM_W-bit (LIM_W = 10 + clog2(LEVEL_SCALE + 1), 14 at default scale) bit-serial divider
// that forms message quota * LEVEL_SCALE / window length, then one multiply and a subtract.
// The next item is accepted in the cycle after its result is loaded; a result still waiting
// for res.ready holds the sequencer in write back until the output register frees up. A
// finished result waits in the output register while the next item is accepted.
// Register writes are taken in any cycle and must only happen while the block is idle.
module flood_rate_limiter_unit #(
	parameter int USERS       = frl_pkg::FRL_USERS,
	parameter int LEVEL_SCALE = frl_pkg::FRL_LEVEL_SCALE
) (
	input  logic      clk,
	input  logic      arst_n,
	frl_msg_if.sink   msg,
	frl_res_if.source res,
	frl_cfg_if.sink   cfg
);
	import frl_pkg::*;

	localparam int ADDR_W = $clog2(USERS);
	localparam int LIM_W  = MSGS_W + $clog2(LEVEL_SCALE + 1);
	localparam int PROD_W = TIME_W + LIM_W;

	state_t              state_q;
	state_t              state_d;
	logic [MSGS_W-1:0]   quota_q;
	logic [FTIME_W-1:0]  window_q;
	logic [TIME_W-1:0]   lnt_q;
	logic [ADDR_W-1:0]   clr_q;
	item_t               item_q;
	logic [ADDR_W-1:0]   idx_q;
	logic                in_range_q;
	logic [LEVEL_W-1:0]  lvl_q;
	logic [TIME_W-1:0]   seen_q;
	logic [OFF_W-1:0]    off_q;
	logic [TIME_W-1:0]   gap_q;
	logic [PROD_W-1:0]   prod_q;
	logic                drop_w_q;
	notice_t             code_w_q;
	logic                res_valid_q;
	logic                drop_q;
	notice_t             code_q;

	entry_t              mem [USERS];
	entry_t              rd_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_wa;
	entry_t              mem_wd;

	logic                msg_xfer;
	logic                done_fire;
	logic                div_start;
	div_sts_t            div_sts;
	logic [LIM_W-1:0]    rate;
	logic [LIM_W-1:0]    limit;
	logic [FTIME_W-1:0]  divisor;

	logic                is_add;
	logic                is_ign;
	logic                later;
	logic [TIME_W-1:0]   gap;
	logic                expire;
	logic                off_hi;
	logic                drain;
	logic                notice_fire;
	logic                over;
	logic [LEVEL_W:0]    sum_amt;
	logic [LEVEL_W:0]    sum_scale;

	assign msg_xfer  = msg.valid && msg.ready;
	assign limit     = LIM_W'(quota_q) * LIM_W'(LEVEL_SCALE);
	assign divisor   = (window_q == '0) ? FTIME_W'(1) : window_q;

	assign is_add    = item_q.action == ACT_ADD;
	assign is_ign    = item_q.ignored && !item_q.admin;
	assign later     = item_q.now > seen_q;
	assign gap       = item_q.now - seen_q;
	assign expire    = later && (gap > IGNORE_SECONDS);
	assign off_hi    = off_q > OFF_BASE;
	assign drain     = (seen_q != '0) && later;
	assign over      = lvl_q > LEVEL_W'(limit);
	assign sum_amt   = {1'b0, lvl_q} + (LEVEL_W + 1)'(item_q.amount);
	assign sum_scale = {1'b0, lvl_q} + (LEVEL_W + 1)'(LEVEL_SCALE);
	assign notice_fire = (state_q == ST_EVAL) && in_range_q && !is_add && !item_q.foreign &&
		is_ign && (lvl_q == '0) && (lnt_q != item_q.now);

	frl_div #(
		.DW(LIM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (limit),
		.divisor  (divisor),
		.quotient (rate),
		.sts      (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		msg.ready = 1'b0;
		div_start = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(USERS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				msg.ready = 1'b1;
				if (msg.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (!in_range_q || is_add || item_q.foreign || is_ign || quota_q == '0) begin
					state_d = ST_DONE;
				end else if (off_hi) begin
					state_d = expire ? ST_ADD : ST_DONE;
				end else if (drain) begin
					state_d   = ST_DIV;
					div_start = 1'b1;
				end else begin
					state_d = ST_ADD;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_SUB;
			end
			ST_SUB: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!res_valid_q || res.ready) begin
					done_fire = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state, registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q     <= '0;
			window_q    <= FTIME_W'(1);
			lnt_q       <= '0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					CFG_MSG_QUOTA: quota_q  <= cfg.data[MSGS_W-1:0];
					CFG_WINDOW:    window_q <= cfg.data[FTIME_W-1:0];
					default: ;
				endcase
			end
			if (notice_fire) begin
				lnt_q <= item_q.now;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (done_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			drop_q <= drop_w_q;
			code_q <= code_w_q;
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (msg_xfer) begin
					item_q.action  <= action_t'(msg.action);
					item_q.now     <= msg.current_time;
					item_q.amount  <= msg.amount;
					item_q.ignored <= msg.on_ignore_list;
					item_q.admin   <= msg.is_admin;
					item_q.may_flood <= msg.may_flood;
					item_q.foreign <= msg.target_foreign;
					idx_q          <= ADDR_W'(msg.user_id);
					in_range_q     <= 32'(msg.user_id) < 32'(USERS);
				end
			end
			ST_READ: begin
				lvl_q    <= rd_q.level;
				seen_q   <= rd_q.last_seen;
				off_q    <= rd_q.offense;
				drop_w_q <= 1'b0;
				code_w_q <= NOTICE_NONE;
			end
			ST_EVAL: begin
				if (!in_range_q) begin
					drop_w_q <= 1'b0;
				end else if (is_add) begin
					lvl_q <= sum_amt[LEVEL_W] ? LEVEL_MAX : sum_amt[LEVEL_W-1:0];
				end else if (item_q.foreign) begin
					drop_w_q <= 1'b0;
				end else if (is_ign) begin
					drop_w_q <= 1'b1;
					if (notice_fire) begin
						lvl_q    <= LEVEL_W'(1);
						code_w_q <= NOTICE_IGNORE;
					end
				end else if (quota_q == '0) begin
					drop_w_q <= 1'b0;
				end else if (off_hi) begin
					if (expire) begin
						off_q  <= off_q - OFF_BASE;
						seen_q <= item_q.now;
						lvl_q  <= '0;
					end else begin
						drop_w_q <= 1'b1;
					end
				end else begin
					gap_q <= gap;
				end
			end
			ST_MUL: begin
				prod_q <= PROD_W'(gap_q) * PROD_W'(rate);
			end
			ST_SUB: begin
				lvl_q <= (PROD_W'(lvl_q) > prod_q) ? lvl_q - prod_q[LEVEL_W-1:0] : '0;
			end
			ST_ADD: begin
				seen_q <= item_q.now;
				lvl_q  <= sum_scale[LEVEL_W] ? LEVEL_MAX : sum_scale[LEVEL_W-1:0];
			end
			ST_CMP: begin
				if (over) begin
					if (item_q.may_flood) begin
						lvl_q <= '0;
					end else if (off_q == OFF_CLEAN || off_q == OFF_ONCE) begin
						code_w_q <= (off_q == OFF_CLEAN) ? NOTICE_FIRST : NOTICE_LAST;
						off_q    <= (off_q == OFF_CLEAN) ? OFF_FIRST_IGNORE : OFF_LAST_IGNORE;
						seen_q   <= item_q.now;
						lvl_q    <= '0;
						drop_w_q <= 1'b1;
					end else if (off_q == OFF_TWICE) begin
						code_w_q <= NOTICE_BAN;
						drop_w_q <= 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// user table
	assign mem_we = (state_q == ST_CLEAR) || (done_fire && in_range_q);
	assign mem_wa = (state_q == ST_CLEAR) ? clr_q : idx_q;
	always_comb begin
		mem_wd.level     = lvl_q;
		mem_wd.last_seen = seen_q;
		mem_wd.offense   = off_q;
		if (state_q == ST_CLEAR) begin
			mem_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[ADDR_W'(msg.user_id)];
	end

	assign cfg.ready       = 1'b1;
	assign res.valid       = res_valid_q;
	assign res.drop        = drop_q;
	assign res.notice_code = code_q;

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		msg_xfer |=> !msg.ready)
		else $error("input ready right after a transfer");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_sts.busy)
		else $error("divider started while busy");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside write back");
`endif

endmodule

>>> tb/flood_rate_limiter_unit_tb.sv
// testbench for the flood rate limiter: directed and random traffic against a predictor
module flood_rate_limiter_unit_tb;
	import frl_pkg::*;

	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		action_t             action;
		logic [UID_W-1:0]    user_id;
		logic [TIME_W-1:0]   now;
		logic [AMOUNT_W-1:0] amount;
		logic                ignored;
		logic                admin;
		logic                may_flood;
		logic                foreign;
	} msg_item_t;

	typedef struct {
		logic    drop;
		notice_t code;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	frl_msg_if msg ();
	frl_res_if res ();
	frl_cfg_if cfg ();

	flood_rate_limiter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.res    (res),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// predicted user table and limits
	logic [LEVEL_W-1:0] lvl_tab [FRL_USERS];
	logic [TIME_W-1:0]  seen_tab [FRL_USERS];
	logic [OFF_W-1:0]   offense_tab [FRL_USERS];
	logic [TIME_W-1:0]  notice_stamp;
	logic [MSGS_W-1:0]  cfg_msgs;
	logic [FTIME_W-1:0] cfg_window;

	msg_item_t msg_backlog [$];
	verdict_t  verdict_q [$];
	msg_item_t next_msg;
	msg_item_t taken_msg;
	verdict_t  want;

	logic              msg_taken = 1'b0;
	logic              calm = 1'b0;
	logic [TIME_W-1:0] wall = 32'd1000;
	int send_gap = 0;
	int stall_left = 0;
	int quiet = 0;
	int errors = 0;
	int n_items = 0;
	int n_adds = 0;
	int n_results = 0;
	int n_drops = 0;
	int n_writes = 0;
	int n_notice [5] = '{default: 0};

	function automatic logic [LEVEL_W-1:0] level_plus(input logic [LEVEL_W-1:0] a,
		input logic [63:0] b);
		logic [63:0] s;
		s = 64'(a) + b;
		return (s > 64'(LEVEL_MAX)) ? LEVEL_MAX : s[LEVEL_W-1:0];
	endfunction

	function automatic verdict_t police_message(input msg_item_t it);
		verdict_t          v;
		logic [63:0]       limit;
		logic [63:0]       rate;
		logic [63:0]       span;
		logic [TIME_W-1:0] elapsed;
		logic [UID_W-1:0]  u;
		v.drop = 1'b0;
		v.code = NOTICE_NONE;
		u = it.user_id;
		if (it.action == ACT_ADD) begin
			lvl_tab[u] = level_plus(lvl_tab[u], 64'(it.amount));
			return v;
		end
		if (it.foreign)
			return v;
		if (it.ignored && !it.admin) begin
			if (lvl_tab[u] == '0 && notice_stamp != it.now) begin
				lvl_tab[u] = LEVEL_W'(1);
				notice_stamp = it.now;
				v.code = NOTICE_IGNORE;
			end
			v.drop = 1'b1;
			return v;
		end
		if (cfg_msgs == '0)
			return v;
		if (offense_tab[u] > OFF_BASE) begin
			elapsed = it.now - seen_tab[u];
			if (it.now > seen_tab[u] && elapsed > IGNORE_SECONDS) begin
				offense_tab[u] = offense_tab[u] - OFF_BASE;
				seen_tab[u] = it.now;
				lvl_tab[u] = '0;
			end else begin
				v.drop = 1'b1;
				return v;
			end
		end
		limit = 64'(cfg_msgs) * 64'(FRL_LEVEL_SCALE);
		if (seen_tab[u] != '0 && it.now > seen_tab[u]) begin
			rate = limit / ((cfg_window == '0) ? 64'd1 : 64'(cfg_window));
			elapsed = it.now - seen_tab[u];
			span = 64'(elapsed) * rate;
			lvl_tab[u] = (64'(lvl_tab[u]) > span) ? LEVEL_W'(64'(lvl_tab[u]) - span) : '0;
		end
		seen_tab[u] = it.now;
		lvl_tab[u] = level_plus(lvl_tab[u], 64'(FRL_LEVEL_SCALE));
		if (64'(lvl_tab[u]) <= limit)
			return v;
		if (it.may_flood) begin
			lvl_tab[u] = '0;
			return v;
		end
		if (offense_tab[u] == OFF_CLEAN || offense_tab[u] == OFF_ONCE) begin
			v.code = (offense_tab[u] == OFF_CLEAN) ? NOTICE_FIRST : NOTICE_LAST;
			offense_tab[u] = (offense_tab[u] == OFF_CLEAN) ? OFF_FIRST_IGNORE : OFF_LAST_IGNORE;
			seen_tab[u] = it.now;
			lvl_tab[u] = '0;
			v.drop = 1'b1;
			return v;
		end
		if (offense_tab[u] == OFF_TWICE) begin
			v.code = NOTICE_BAN;
			v.drop = 1'b1;
		end
		return v;
	endfunction

	function automatic void post_msg(input action_t a, input int uid, input logic [TIME_W-1:0] t,
		input logic [AMOUNT_W-1:0] amt, input logic ign, input logic adm, input logic mf,
		input logic fgn);
		msg_item_t it;
		it.action = a;
		it.user_id = UID_W'(uid);
		it.now = t;
		it.amount = amt;
		it.ignored = ign;
		it.admin = adm;
		it.may_flood = mf;
		it.foreign = fgn;
		msg_backlog.push_back(it);
	endfunction

	// bursts mostly from a small pool of users so that offense states escalate
	task automatic queue_traffic(input int count);
		msg_item_t        it;
		int               burst;
		logic [UID_W-1:0] uid;
		while (count > 0) begin
			if ($urandom_range(0, 4) == 0)
				uid = UID_W'($urandom_range(0, FRL_USERS - 1));
			else
				uid = UID_W'($urandom_range(0, 7));
			case ($urandom_range(0, 19))
				0: wall = $urandom();
				1: wall = wall - $urandom_range(1, 40);
				2, 3, 4, 5: wall = wall + $urandom_range(28, 40);
				default: wall = wall + $urandom_range(0, 3);
			endcase
			burst = $urandom_range(1, 8);
			while (burst > 0 && count > 0) begin
				it.action = ACT_CHECK;
				it.user_id = uid;
				it.now = wall;
				it.amount = AMOUNT_W'($urandom());
				it.ignored = ($urandom_range(0, 11) == 0);
				it.admin = ($urandom_range(0, 5) == 0);
				it.may_flood = ($urandom_range(0, 9) == 0);
				it.foreign = ($urandom_range(0, 9) == 0);
				if ($urandom_range(0, 9) == 0) begin
					it.action = ACT_ADD;
					if ($urandom_range(0, 1) == 0)
						it.amount = AMOUNT_W'($urandom_range(0, 40));
				end
				msg_backlog.push_back(it);
				if ($urandom_range(0, 3) == 0)
					wall = wall + 32'd1;
				burst--;
				count--;
			end
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			CFG_MSG_QUOTA: cfg_msgs = val[MSGS_W-1:0];
			default: cfg_window = val;
		endcase
		n_writes++;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_limits(input logic [CFG_DATA_W-1:0] msgs,
		input logic [CFG_DATA_W-1:0] window);
		write_reg(CFG_MSG_QUOTA, msgs);
		write_reg(CFG_WINDOW, window);
	endtask

	task automatic drain();
		@(posedge clk);
		while (msg_backlog.size() != 0 || msg.valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// message driver
	always @(negedge clk) begin
		if (!msg.valid || msg_taken) begin
			if (send_gap > 0) begin
				msg.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (msg_backlog.size() != 0) begin
				next_msg = msg_backlog.pop_front();
				msg.valid <= 1'b1;
				msg.action <= next_msg.action;
				msg.user_id <= next_msg.user_id;
				msg.current_time <= next_msg.now;
				msg.amount <= next_msg.amount;
				msg.on_ignore_list <= next_msg.ignored;
				msg.is_admin <= next_msg.admin;
				msg.may_flood <= next_msg.may_flood;
				msg.target_foreign <= next_msg.foreign;
				if (!calm && $urandom_range(0, 5) == 0)
					send_gap <= $urandom_range(1, 9);
			end else begin
				msg.valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			res.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			res.ready <= 1'b0;
			stall_left <= $urandom_range(0, 8);
		end else begin
			res.ready <= 1'b1;
		end
	end

	// transfer monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			msg_taken = msg.valid && msg.ready;
			if (msg_taken) begin
				taken_msg.action = action_t'(msg.action);
				taken_msg.user_id = msg.user_id;
				taken_msg.now = msg.current_time;
				taken_msg.amount = msg.amount;
				taken_msg.ignored = msg.on_ignore_list;
				taken_msg.admin = msg.is_admin;
				taken_msg.may_flood = msg.may_flood;
				taken_msg.foreign = msg.target_foreign;
				verdict_q.push_back(police_message(taken_msg));
				n_items++;
				if (taken_msg.action == ACT_ADD)
					n_adds++;
			end
			if (res.valid && res.ready) begin
				n_results++;
				if (verdict_q.size() == 0) begin
					$display("%0t: result with nothing outstanding: drop=%0b notice=%0d",
						$time, res.drop, res.notice_code);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (res.drop !== want.drop) begin
						$display("%0t: drop mismatch: expected %0b, actual %0b",
							$time, want.drop, res.drop);
						errors++;
					end
					if (res.notice_code !== want.code) begin
						$display("%0t: notice_code mismatch: expected %0d, actual %0d",
							$time, want.code, res.notice_code);
						errors++;
					end
					n_drops += want.drop;
					n_notice[int'(want.code)]++;
				end
			end
			if (msg_taken || (res.valid && res.ready) || (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end else begin
			msg_taken = 1'b0;
		end
	end

	initial begin
		while (quiet < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < FRL_USERS; i++) begin
			lvl_tab[i] = '0;
			seen_tab[i] = '0;
			offense_tab[i] = '0;
		end
		notice_stamp = '0;
		cfg_msgs = '0;
		cfg_window = FTIME_W'(1);
		arst_n = 1'b0;
		msg.valid = 1'b0;
		msg.action = ACT_CHECK;
		msg.user_id = '0;
		msg.current_time = '0;
		msg.amount = '0;
		msg.on_ignore_list = 1'b0;
		msg.is_admin = 1'b0;
		msg.may_flood = 1'b0;
		msg.target_foreign = 1'b0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_MSG_QUOTA;
		cfg.data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// policing off at reset values; ignore-list notices
		post_msg(ACT_CHECK, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_CHECK, 3, 32'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_CHECK, 3, 32'd5, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_CHECK, 4, 32'd5, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_ADD, 255, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
		post_msg(ACT_ADD, 0, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		drain();

		// two messages per second, zero window treated as one second
		set_limits(16'hFC02, 16'h0000);
		repeat (SETTLE_CYCLES) @(posedge clk);
		repeat (3) post_msg(ACT_CHECK, 1, 32'd100, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_CHECK, 1, 32'd110, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_CHECK, 1, 32'd90, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		repeat (3) post_msg(ACT_CHECK, 1, 32'd141, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		repeat (4) post_msg(ACT_CHECK, 1, 32'd172, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_ADD, 2, 32'd200, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_CHECK, 2, 32'd200, 16'd0, 1'b0, 1'b0, 1'b1, 1'b0);
		post_msg(ACT_CHECK, 6, 32'd200, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1);
		post_msg(ACT_CHECK, 8, 32'd300, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_ADD, 8, 32'd300, 16'd25, 1'b0, 1'b0, 1'b0, 1'b0);
		post_msg(ACT_CHECK, 8, 32'd301, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0);
		drain();

		set_limits(16'h0003, 16'h0002);
		queue_traffic(75);
		drain();
		set_limits(16'h0001, 16'h0001);
		queue_traffic(75);
		drain();
		set_limits(16'hFFFF, 16'hFFFF);
		queue_traffic(75);
		drain();
		set_limits(16'h0000, 16'h0007);
		queue_traffic(75);
		drain();
		set_limits(16'hA804, 16'hFFFF);
		queue_traffic(75);
		drain();

		calm = 1'b1;
		set_limits(16'h0002, 16'h0003);
		queue_traffic(75);
		drain();

		if (verdict_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, verdict_q.size());
			errors += verdict_q.size();
		end
		$display("covered %0d items (%0d adds) under %0d register writes, %0d results, %0d drops",
			n_items, n_adds, n_writes, n_results, n_drops);
		$display("notices: ignore %0d, first offense %0d, last warning %0d, ban request %0d",
			n_notice[NOTICE_IGNORE], n_notice[NOTICE_FIRST], n_notice[NOTICE_LAST],
			n_notice[NOTICE_BAN]);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> flood_rate_limiter_unit.f
rtl/frl_pkg.sv
rtl/frl_if.sv
rtl/frl_div.sv
rtl/flood_rate_limiter_unit.sv
tb/flood_rate_limiter_unit_tb.sv
